[rtl/dhcp_request_parser_assert.svh]
// Assertion macros of the DHCP request parser RTL.
`ifndef DHCP_REQUEST_PARSER_ASSERT_SVH
`define DHCP_REQUEST_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

`define DHCPRP_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("dhcp_request_parser: same-cycle check failed");

`define DHCPRP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("dhcp_request_parser: next-cycle check failed");

`else

`define DHCPRP_ASSERT_SAME(label, clk, rst_n, cond, expr)

`define DHCPRP_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

[rtl/dhcprp_pkg.sv]
// Types and constants of the DHCP request parser.
`default_nettype none

package dhcprp_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_OP    = 3'd1,
        ST_BAD_HTYPE = 3'd2,
        ST_BAD_HLEN  = 3'd3,
        ST_SHORT_HDR = 3'd4,
        ST_SHORT_OPT = 3'd5
    } status_t;

    typedef enum logic [6:0] {
        PH_HEADER   = 7'b0000001,
        PH_COOKIE   = 7'b0000010,
        PH_OPT_ID   = 7'b0000100,
        PH_OPT_LEN  = 7'b0001000,
        PH_OPT_VAL  = 7'b0010000,
        PH_OPT_SKIP = 7'b0100000,
        PH_DONE     = 7'b1000000
    } phase_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  message_type;
        logic [31:0] transaction_id;
        logic        broadcast;
        logic [31:0] client_ip;
        logic [47:0] client_mac;
    } result_t;

    localparam logic [31:0] OPTIONS_COOKIE = 32'h6382_5363;
    localparam logic [7:0]  OP_REQUEST   = 8'd1;
    localparam logic [7:0]  HTYPE_ETH    = 8'd1;
    localparam logic [7:0]  MAC_LEN      = 8'd6;
    localparam logic [7:0]  OPT_PAD      = 8'd0;
    localparam logic [7:0]  OPT_END      = 8'd255;
    localparam logic [7:0]  OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0]  TYPE_LEN     = 8'd1;

    localparam logic [7:0]  POS_OP       = 8'd0;
    localparam logic [7:0]  POS_HTYPE    = 8'd1;
    localparam logic [7:0]  POS_HLEN     = 8'd2;
    localparam logic [7:0]  POS_XID      = 8'd4;
    localparam logic [7:0]  POS_FLAGS    = 8'd10;
    localparam logic [7:0]  POS_CIADDR   = 8'd12;
    localparam logic [7:0]  POS_CHADDR   = 8'd28;
    localparam int          CHADDR_LEN   = 16;
    localparam int          SNAME_LEN    = 64;
    localparam int          BOOTFILE_LEN = 128;
    localparam logic [7:0]  HEADER_LEN   = 8'(28 + CHADDR_LEN + SNAME_LEN + BOOTFILE_LEN);
    localparam logic [7:0]  COOKIE_END   = HEADER_LEN + 8'd4;
    localparam int          BCAST_BIT    = 7;

endpackage

`default_nettype wire

[rtl/dhcp_request_parser.sv]
// Top level of the DHCP request parser.
`default_nettype none

// The parser takes one message byte per word and keeps up with one word every clock
// cycle. The result of a message is registered and shown in the cycle after its last
// byte is taken; ordinary bytes are always accepted, and a last byte is stalled only
// while the previous result is still held by a stalled result channel.
module dhcp_request_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        msg_valid,
    output logic             msg_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [2:0]       status,
    output logic [7:0]       message_type,
    output logic [31:0]      transaction_id,
    output logic             broadcast,
    output logic [31:0]      client_ip,
    output logic [47:0]      client_mac
);
    import dhcprp_pkg::*;

    `include "dhcp_request_parser_assert.svh"

    logic    fire;
    logic    fire_last;
    result_t res_comb;
    result_t res_q;

    assign msg_stall = last & result_valid & result_stall;
    assign fire      = msg_valid & ~msg_stall;
    assign fire_last = fire & last;

    dhcprp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (data_byte),
        .last      (last),
        .res       (res_comb)
    );

    dhcprp_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (fire_last),
        .res_in (res_comb),
        .hold   (result_stall),
        .valid  (result_valid),
        .res_q  (res_q)
    );

    assign status         = res_q.status;
    assign message_type   = res_q.message_type;
    assign transaction_id = res_q.transaction_id;
    assign broadcast      = res_q.broadcast;
    assign client_ip      = res_q.client_ip;
    assign client_mac     = res_q.client_mac;

    `DHCPRP_ASSERT_NEXT(a_last_gives_result, clk, rst_n, fire_last, result_valid)
    `DHCPRP_ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !result_valid && !fire_last, !result_valid)
    `DHCPRP_ASSERT_SAME(a_fail_clears_fields, clk, rst_n, result_valid && status != ST_OK,
        message_type == 8'd0 && transaction_id == 32'd0 && !broadcast
        && client_ip == 32'd0 && client_mac == 48'd0)

endmodule

`default_nettype wire

[rtl/dhcprp_core.sv]
// Per-word parse state of the DHCP request parser and the result it forms.
`default_nettype none

module dhcprp_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last,
    output dhcprp_pkg::result_t     res
);
    import dhcprp_pkg::*;

    logic [7:0]  pos_reg, pos_next;
    phase_t      phase_reg, phase_next;
    status_t     err_reg, err_next;
    logic        is_type_reg, is_type_next;
    logic [7:0]  skip_reg, skip_next;
    logic [31:0] cookie_reg, cookie_next;
    logic [31:0] xid_reg, xid_next;
    logic        bcast_reg, bcast_next;
    logic [31:0] ip_reg, ip_next;
    logic [47:0] mac_reg, mac_next;
    logic [7:0]  type_reg, type_next;

    always_comb
    begin
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        err_next     = err_reg;
        is_type_next = is_type_reg;
        skip_next    = skip_reg;
        cookie_next  = cookie_reg;
        xid_next     = xid_reg;
        bcast_next   = bcast_reg;
        ip_next      = ip_reg;
        mac_next     = mac_reg;
        type_next    = type_reg;

        if (err_reg == ST_OK)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == POS_OP && data_byte != OP_REQUEST)
                        err_next = ST_BAD_OP;
                    if (pos_reg == POS_HTYPE && data_byte != HTYPE_ETH)
                        err_next = ST_BAD_HTYPE;
                    if (pos_reg == POS_HLEN && data_byte != MAC_LEN)
                        err_next = ST_BAD_HLEN;
                    if (pos_reg >= POS_XID && pos_reg < POS_XID + 8'd4)
                        xid_next = {xid_reg[23:0], data_byte};
                    if (pos_reg == POS_FLAGS)
                        bcast_next = data_byte[BCAST_BIT];
                    if (pos_reg >= POS_CIADDR && pos_reg < POS_CIADDR + 8'd4)
                        ip_next = {ip_reg[23:0], data_byte};
                    if (pos_reg >= POS_CHADDR && pos_reg < POS_CHADDR + MAC_LEN)
                        mac_next = {mac_reg[39:0], data_byte};
                    pos_next = pos_reg + 8'd1;
                    if (pos_next == HEADER_LEN)
                        phase_next = PH_COOKIE;
                    else if (last && err_next == ST_OK)
                        err_next = ST_SHORT_HDR;
                end
                PH_COOKIE:
                begin
                    cookie_next = {cookie_reg[23:0], data_byte};
                    pos_next    = pos_reg + 8'd1;
                    if (pos_next == COOKIE_END)
                        phase_next = (cookie_next == OPTIONS_COOKIE) ? PH_OPT_ID : PH_DONE;
                end
                PH_OPT_ID:
                begin
                    if (data_byte == OPT_END)
                        phase_next = PH_DONE;
                    else if (!last && data_byte != OPT_PAD)
                    begin
                        is_type_next = (data_byte == OPT_MSG_TYPE);
                        phase_next   = PH_OPT_LEN;
                    end
                end
                PH_OPT_LEN:
                begin
                    if (is_type_reg && data_byte == TYPE_LEN)
                    begin
                        if (last)
                            err_next = ST_SHORT_OPT;
                        else
                            phase_next = PH_OPT_VAL;
                    end
                    else if (data_byte == 8'd0)
                        phase_next = PH_OPT_ID;
                    else if (last)
                        err_next = ST_SHORT_OPT;
                    else
                    begin
                        skip_next  = data_byte;
                        phase_next = PH_OPT_SKIP;
                    end
                end
                PH_OPT_VAL:
                begin
                    type_next  = data_byte;
                    phase_next = PH_OPT_ID;
                end
                PH_OPT_SKIP:
                begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_next == 8'd0)
                        phase_next = PH_OPT_ID;
                    else if (last)
                        err_next = ST_SHORT_OPT;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        res.status = err_next;
        if (err_next == ST_OK)
        begin
            res.message_type   = type_next;
            res.transaction_id = xid_next;
            res.broadcast      = bcast_next;
            res.client_ip      = ip_next;
            res.client_mac     = mac_next;
        end
        else
        begin
            res.message_type   = 8'd0;
            res.transaction_id = 32'd0;
            res.broadcast      = 1'b0;
            res.client_ip      = 32'd0;
            res.client_mac     = 48'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 8'd0;
            phase_reg   <= PH_HEADER;
            err_reg     <= ST_OK;
            is_type_reg <= 1'b0;
            skip_reg    <= 8'd0;
            cookie_reg  <= 32'd0;
            xid_reg     <= 32'd0;
            bcast_reg   <= 1'b0;
            ip_reg      <= 32'd0;
            mac_reg     <= 48'd0;
            type_reg    <= 8'd0;
        end
        else if (fire)
        begin
            if (last)
            begin
                pos_reg     <= 8'd0;
                phase_reg   <= PH_HEADER;
                err_reg     <= ST_OK;
                is_type_reg <= 1'b0;
                skip_reg    <= 8'd0;
                cookie_reg  <= 32'd0;
                xid_reg     <= 32'd0;
                bcast_reg   <= 1'b0;
                ip_reg      <= 32'd0;
                mac_reg     <= 48'd0;
                type_reg    <= 8'd0;
            end
            else
            begin
                pos_reg     <= pos_next;
                phase_reg   <= phase_next;
                err_reg     <= err_next;
                is_type_reg <= is_type_next;
                skip_reg    <= skip_next;
                cookie_reg  <= cookie_next;
                xid_reg     <= xid_next;
                bcast_reg   <= bcast_next;
                ip_reg      <= ip_next;
                mac_reg     <= mac_next;
                type_reg    <= type_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/dhcprp_out_reg.sv]
// Result register of the DHCP request parser with its valid flag.
`default_nettype none

module dhcprp_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire dhcprp_pkg::result_t res_in,
    input  wire logic               hold,
    output logic                    valid,
    output dhcprp_pkg::result_t     res_q
);
    import dhcprp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign valid_next = load | (valid_reg & hold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    assign valid = valid_reg;
    assign res_q = res_reg;

endmodule

`default_nettype wire
